>>> rtl/mri_pkg.sv
// ----------------------------------------------------------------------------
// Motor reversal interlock package
// Shared codes, state record and reset constants for the interlock encoder.
// ----------------------------------------------------------------------------
package mri_pkg;

	// Function code carried by each input transaction.
	typedef enum logic [1:0] {
		FUNC_SPEED      = 2'd0,
		FUNC_LIMIT_EDGE = 2'd1,
		FUNC_UPDATE_POS = 2'd2,
		FUNC_RESET_POS  = 2'd3
	} func_t;

	// Status code returned with each result transaction.
	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_COOLING  = 2'd1,
		STATUS_AT_LIMIT = 2'd2
	} status_t;

	// Architectural state of the interlock.
	typedef struct packed {
		logic signed [7:0] applied_drive;
		logic              cooling;
		logic [31:0]       cool_stamp;
		logic [15:0]       position_count;
		logic [15:0]       last_encoder;
		logic signed [7:0] drive_out;
	} mri_state_t;

	localparam logic [31:0]       COOLDOWN_RESET = 32'd100000;
	localparam logic signed [7:0] DRIVE_MAX      = 8'sd127;
	localparam logic signed [7:0] DRIVE_MIN_RAW  = -8'sd128;

endpackage

>>> rtl/mri_step.sv
// ----------------------------------------------------------------------------
// Interlock step logic
// Computes the next interlock state, status and drive write for one
// transaction from the present state. Purely combinational.
// ----------------------------------------------------------------------------
module mri_step (
	input  mri_pkg::mri_state_t cur_state,
	input  logic [31:0]         cooldown_us,
	input  mri_pkg::func_t      func,
	input  logic signed [7:0]   speed,
	input  logic [31:0]         now_us,
	input  logic                limit_pressed,
	input  logic [15:0]         encoder_raw,
	output mri_pkg::mri_state_t next_state,
	output mri_pkg::status_t    status,
	output logic                drive_write
);
	import mri_pkg::*;

	logic signed [7:0] req_drive;
	logic signed [7:0] base_drive;
	logic [15:0]       enc_diff;
	logic [15:0]       moved_pos;
	logic [31:0]       elapsed;
	logic              is_command;
	logic              still_cooling;
	logic              reversal;

	// Negate the extend speed so that positive retracts; the most negative
	// speed saturates to full retract. A limit edge acts as a stop.
	always_comb begin
		if (func != FUNC_SPEED) begin
			req_drive = '0;
		end else if (speed == DRIVE_MIN_RAW) begin
			req_drive = DRIVE_MAX;
		end else begin
			req_drive = -speed;
		end
	end

	// Encoder difference, signed by the direction of the applied drive.
	assign enc_diff  = encoder_raw - cur_state.last_encoder;
	assign moved_pos = (cur_state.applied_drive > 8'sd0) ?
		cur_state.position_count - enc_diff : cur_state.position_count + enc_diff;

	// Wrapping time since the brake stamp.
	assign elapsed       = now_us - cur_state.cool_stamp;
	assign still_cooling = cur_state.cooling && (elapsed < cooldown_us);

	assign is_command = (func == FUNC_SPEED) ||
		((func == FUNC_LIMIT_EDGE) && limit_pressed && (cur_state.applied_drive > 8'sd0));

	// Direction seen by the reversal check, once an expired cooldown has cleared it.
	assign base_drive = cur_state.cooling ? 8'sd0 : cur_state.applied_drive;
	assign reversal   = ((base_drive < 8'sd0) && (req_drive > 8'sd0)) ||
		((base_drive > 8'sd0) && (req_drive < 8'sd0)) ||
		((base_drive != 8'sd0) && (req_drive == 8'sd0));

	// Next state and result.
	always_comb begin
		next_state  = cur_state;
		status      = STATUS_OK;
		drive_write = 1'b0;
		case (func)
			FUNC_SPEED, FUNC_LIMIT_EDGE: begin
				if (is_command) begin
					if (still_cooling) begin
						status = STATUS_COOLING;
					end else begin
						if (cur_state.cooling) begin
							next_state.position_count = moved_pos;
							next_state.last_encoder   = encoder_raw;
							next_state.cooling        = 1'b0;
							next_state.applied_drive  = '0;
						end
						if (reversal) begin
							next_state.cooling    = 1'b1;
							next_state.cool_stamp = now_us;
							next_state.drive_out  = '0;
							drive_write           = 1'b1;
							status                = STATUS_COOLING;
						end else if ((req_drive > 8'sd0) && limit_pressed) begin
							status = STATUS_AT_LIMIT;
						end else begin
							next_state.applied_drive = req_drive;
							next_state.drive_out     = req_drive;
							drive_write              = 1'b1;
						end
					end
				end
			end
			FUNC_UPDATE_POS: begin
				next_state.position_count = moved_pos;
				next_state.last_encoder   = encoder_raw;
			end
			FUNC_RESET_POS: begin
				next_state.position_count = '0;
				next_state.last_encoder   = encoder_raw;
			end
			default: begin
				next_state = cur_state;
			end
		endcase
	end

endmodule

>>> rtl/motor_reversal_interlock_encoder.sv
// ----------------------------------------------------------------------------
// Motor reversal interlock encoder
// An accepted input transaction is held in the input register; its result is
// then registered in the result register. Throughput: one transaction per
// cycle unless the result side stalls; step logic sits between the registers.
// Reset: arst_n clears all interlock state, sets cooldown_us to 100000 and
// empties both stages.
// ----------------------------------------------------------------------------
module motor_reversal_interlock_encoder (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration
	input  logic                cooldown_we,
	input  logic [31:0]         cooldown_wdata,
	// Command channel
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  logic [1:0]          func,
	input  logic signed [7:0]   speed,
	input  logic [31:0]         now_us,
	input  logic                limit_pressed,
	input  logic [15:0]         encoder_raw,
	// Result channel
	output logic                res_valid,
	input  logic                res_stall,
	output logic [1:0]          status,
	output logic                drive_write,
	output logic signed [7:0]   motor_drive,
	output logic signed [15:0]  position
);
	import mri_pkg::*;

	logic              valid_s1;
	func_t             func_s1;
	logic signed [7:0] speed_s1;
	logic [31:0]       now_s1;
	logic              limit_s1;
	logic [15:0]       enc_s1;
	logic              advance;
	logic              res_valid_q;
	status_t           status_q;
	logic              drive_write_q;
	logic [31:0]       cooldown_q;
	mri_state_t        state_q;
	mri_state_t        state_nxt;
	status_t           status_nxt;
	logic              drive_write_nxt;

	// Handshake: the input stage moves on whenever the result register is free or its result is taken.
	assign advance   = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = valid_s1 && !advance;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= COOLDOWN_RESET;
		end else if (cooldown_we) begin
			cooldown_q <= cooldown_wdata;
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			func_s1  <= func_t'(func);
			speed_s1 <= speed;
			now_s1   <= now_us;
			limit_s1 <= limit_pressed;
			enc_s1   <= encoder_raw;
		end
	end

	// Step logic.
	mri_step u_step (
		.cur_state     (state_q),
		.cooldown_us   (cooldown_q),
		.func          (func_s1),
		.speed         (speed_s1),
		.now_us        (now_s1),
		.limit_pressed (limit_s1),
		.encoder_raw   (enc_s1),
		.next_state    (state_nxt),
		.status        (status_nxt),
		.drive_write   (drive_write_nxt)
	);

	// Interlock state commits together with the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q      <= status_nxt;
			drive_write_q <= drive_write_nxt;
		end
	end

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign drive_write = drive_write_q;
	assign motor_drive = state_q.drive_out;
	assign position    = state_q.position_count;

	// A refusal at the limit never rewrites the drive.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (status_q == STATUS_AT_LIMIT) |-> !drive_write_q)
		else $error("drive written on a limit refusal");

	// While cooling down the motor is braked.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.cooling |-> (state_q.drive_out == 8'sd0))
		else $error("drive nonzero during cooldown");

	// Outside a cooldown the applied drive is what the motor sees.
	assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.cooling |-> (state_q.drive_out == state_q.applied_drive))
		else $error("drive and applied drive disagree");

	// The saturated drive never reaches the most negative code.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.applied_drive != DRIVE_MIN_RAW)
		else $error("applied drive out of range");

	// The input side stalls only when a transaction is held there.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && res_valid_q))
		else $error("stall without a held transaction");

endmodule
